// ===== rtl/ese_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ese_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_SCALE = 2'd0,
    CFG_FILTER_WEIGHT = 2'd1,
    CFG_STOP_TIMEOUT = 2'd2,
    CFG_TICK_DIVIDE = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SPEED = 7'b0000010,
    ST_FILT = 7'b0000100,
    ST_MUL = 7'b0001000,
    ST_ACC = 7'b0010000,
    ST_FIN = 7'b0100000,
    ST_OUT = 7'b1000000
  } state_e;

  localparam logic [8:0] WeightOne = 9'd256;
  localparam logic [19:0] UsPerS = 20'd1000000;
  localparam logic signed [31:0] S32Max = 32'sh7fffffff;
  localparam logic signed [31:0] S32Min = 32'sh80000000;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/ese_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ese_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ese_pkg::div_req_t   req_i,
  output ese_pkg::div_rsp_t        rsp_o
);
  import ese_pkg::*;

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [33:0] sub;

  // one quotient bit per cycle, restoring
  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[31:0], quot_q[63]};
    sub = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sub[33]) begin
        rem_d = sub[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quot_q;
endmodule
`default_nettype wire

// ===== rtl/encoder_speed_estimator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | signals                                   | role
// input    | in_valid_i/in_ready_o, op..time_us        | one tick or query transaction
// output   | out_valid_o/out_ready_i, out_channel..    | one result per transaction
// config   | cfg_we_i, cfg_idx_i, cfg_data_i           | register write, no wait
// a tick passes through the speed, finish and output states from accept to result valid
// a query uses up to two passes of the 64-step shared bit-serial divider
// plus a 33-step shift-add multiply for the filter
// reset loads config defaults and clears all per-channel state
// input is held off while a result waits in the output register
module encoder_speed_estimator_unit #(
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [ese_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ese_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic        channel_i,
  input  wire logic        direction_i,
  input  wire logic [31:0] time_us_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_channel_o,
  output logic signed [31:0] position_o,
  output logic [31:0]      period_us_o,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] accel_o,
  output logic             stopped_o,
  output logic             is_query_o
);
  import ese_pkg::*;

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [31:0] scale_q, timeout_q;
  logic [8:0]  weight_q;
  logic [15:0] tdiv_q;

  logic [15:0] dcnt_q [CHANNELS];
  logic [31:0] pos_q [CHANNELS];
  logic [31:0] ltt_q [CHANNELS];
  logic [31:0] per_q [CHANNELS];
  logic        dir_q [CHANNELS];
  logic signed [31:0] filt_q [CHANNELS];
  logic [31:0] lqt_q [CHANNELS];

  state_e st_q, st_d;
  logic        op_q, chn_q, dirn_q;
  logic [31:0] t_q;
  logic        ok_q;
  logic [ChW-1:0] ci;
  logic        stp_q;
  logic signed [31:0] raw_q, now_q, acc_q;
  logic [31:0] dt_q;
  // serial multiplier: accumulator and shifting multiplier/multiplicand
  logic signed [41:0] sum_q;
  logic [41:0] mcand_q;
  logic [32:0] mplr_q;
  logic [5:0]  mcnt_q;

  div_req_t dreq;
  div_rsp_t drsp;

  ese_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign ci = ChW'(chn_q);
  assign in_ready_o = (st_q == ST_IDLE) && !out_valid_o;

  logic [8:0] wsat;
  assign wsat = (weight_q > WeightOne) ? WeightOne : weight_q;

  logic [31:0] age;
  assign age = t_q - ltt_q[ci];

  logic signed [32:0] diff;
  assign diff = {now_q[31], now_q} - {filt_q[ci][31], filt_q[ci]};
  logic [32:0] dmag;
  assign dmag = diff[32] ? 33'(-diff) : 33'(diff);

  logic [63:0] q;
  assign q = drsp.quotient;

  always_comb begin
    dreq = '0;
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i && in_ready_o) st_d = ST_SPEED;
      ST_SPEED: begin
        if (!ok_q || !op_q) st_d = ST_FIN;
        else if (age > timeout_q || per_q[ci] == 32'd0) st_d = ST_FILT;
        else if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.dividend = {32'd0, scale_q};
          dreq.divisor = per_q[ci];
        end else if (drsp.done) st_d = ST_FILT;
      end
      ST_FILT: st_d = ST_MUL;
      ST_MUL: if (mcnt_q == 6'd0) st_d = ST_ACC;
      ST_ACC: begin
        if (dt_q == 32'd0) st_d = ST_FIN;
        else if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.dividend = 64'(dmag) * 64'(UsPerS);
          dreq.divisor = dt_q;
        end else if (drsp.done) st_d = ST_FIN;
      end
      ST_FIN: st_d = ST_OUT;
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      scale_q <= '0;
      weight_q <= 9'd205;
      timeout_q <= 32'd100000;
      tdiv_q <= 16'd1;
      out_valid_o <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        dcnt_q[i] <= '0; pos_q[i] <= '0; ltt_q[i] <= '0; per_q[i] <= '0;
        dir_q[i] <= 1'b0; filt_q[i] <= '0; lqt_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SPEED_SCALE: scale_q <= cfg_data_i;
          CFG_FILTER_WEIGHT: weight_q <= cfg_data_i[8:0];
          CFG_STOP_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_TICK_DIVIDE: tdiv_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (st_q == ST_OUT) out_valid_o <= 1'b1;
      if (st_q == ST_SPEED && ok_q && !op_q) begin
        if (dcnt_q[ci] + 16'd1 >= tdiv_q) begin
          dcnt_q[ci] <= '0;
          dir_q[ci] <= dirn_q;
          pos_q[ci] <= pos_q[ci] + (dirn_q ? 32'hffffffff : 32'd1);
          per_q[ci] <= t_q - ltt_q[ci];
          ltt_q[ci] <= t_q;
        end else dcnt_q[ci] <= dcnt_q[ci] + 16'd1;
      end
      if (st_q == ST_FIN && ok_q && op_q) begin
        filt_q[ci] <= now_q;
        lqt_q[ci] <= t_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= op_i; chn_q <= channel_i; dirn_q <= direction_i; t_q <= time_us_i;
      ok_q <= (32'(channel_i) < CHANNELS);
      acc_q <= '0;
    end
    if (st_q == ST_SPEED && ok_q && op_q) begin
      stp_q <= age > timeout_q;
      if (age > timeout_q) raw_q <= '0;
      else if (per_q[ci] == 32'd0) raw_q <= dir_q[ci] ? S32Min : S32Max;
      else if (drsp.done) begin
        if (!dir_q[ci]) raw_q <= (q > 64'(S32Max)) ? S32Max : q[31:0];
        else raw_q <= (q > 64'h80000000) ? S32Min : -q[31:0];
      end
    end
    if (st_q == ST_FILT) begin
      // (256-w)*raw + w*prev = 256*prev + (raw-prev)*(256-w); serial over signed raw-prev
      sum_q <= {{2{filt_q[ci][31]}}, filt_q[ci], 8'd0};
      mcand_q <= 42'(WeightOne - wsat);
      mplr_q <= '0;
      mcnt_q <= 6'd34;
      dt_q <= t_q - lqt_q[ci];
    end
    if (st_q == ST_MUL) begin
      if (mcnt_q == 6'd34) begin
        mplr_q <= {raw_q[31], raw_q} - {filt_q[ci][31], filt_q[ci]};
        mcnt_q <= 6'd33;
      end else if (mcnt_q != 6'd0) begin
        // signed multiplier bits: msb has negative weight
        if (mplr_q[0]) begin
          if (mcnt_q == 6'd1) sum_q <= sum_q - $signed(mcand_q);
          else sum_q <= sum_q + $signed(mcand_q);
        end
        mplr_q <= {1'b0, mplr_q[32:1]};
        mcand_q <= {mcand_q[40:0], 1'b0};
        mcnt_q <= mcnt_q - 6'd1;
      end else begin
        now_q <= 32'(sum_q >>> 8);
      end
    end
    if (st_q == ST_ACC && drsp.done) begin
      if (diff[32]) acc_q <= (q > 64'h80000000) ? S32Min : -q[31:0];
      else acc_q <= (q > 64'(S32Max)) ? S32Max : q[31:0];
    end
    if (st_q == ST_FIN) begin
      out_channel_o <= chn_q;
      position_o <= ok_q ? pos_q[ci] : '0;
      period_us_o <= ok_q ? per_q[ci] : '0;
      speed_o <= (ok_q && op_q) ? now_q : '0;
      accel_o <= (ok_q && op_q) ? acc_q : '0;
      stopped_o <= ok_q && op_q && stp_q;
      is_query_o <= ok_q && op_q;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q == ST_OUT)) else $error("result without item");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted");
`endif
endmodule
`default_nettype wire
